[hdl/scrolling_tile_line_scanner_unit_assert.svh]
// Assertion macros used by the checker of the tile line scanner.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SCROLLING_TILE_LINE_SCANNER_UNIT_ASSERT_SVH
`define SCROLLING_TILE_LINE_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STLSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define STLSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/stlsu_pkg.sv]
// Package for the scrolling tile line scanner: payload structs, register indexes,
// shared arithmetic unit types and reset constants. No dependencies.
`default_nettype none

package stlsu_pkg;

	// Width of the shared adder; covers the widest row product plus scroll.
	localparam int ALU_W = 18;

	// Line counter and register widths.
	localparam int LINE_W  = 11;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 16;

	// Value held by a store entry that has not been drawn into.
	localparam logic [7:0] TRANSPARENT = 8'd192;

	// Register reset values.
	localparam logic [LINE_W-1:0] FIRST_LINE_RST = 11'h7D3;
	localparam logic [LINE_W-1:0] END_LINE_RST   = 11'h1E0;
	localparam logic [LINE_W-1:0] VSYNC_ON_RST   = 11'h7DD;
	localparam logic [LINE_W-1:0] VSYNC_OFF_RST  = 11'h7DF;
	localparam logic [3:0]        ROW_SHIFT_RST  = 4'd4;
	localparam logic [4:0]        SCROLL_X_RST   = 5'd0;
	localparam logic [9:0]        SCROLL_Y_RST   = 10'd0;

	// Configuration register indexes.
	typedef enum logic [CFG_IW-1:0] {
		REG_FIRST_LINE = 3'd0,
		REG_END_LINE   = 3'd1,
		REG_VSYNC_ON   = 3'd2,
		REG_VSYNC_OFF  = 3'd3,
		REG_ROW_SHIFT  = 3'd4,
		REG_SCROLL_X   = 3'd5,
		REG_SCROLL_Y   = 3'd6
	} reg_idx_t;

	// Input request.
	typedef struct packed {
		logic       req_type;
		logic [9:0] wr_addr;
		logic [7:0] wr_byte;
	} in_req_t;

	// Result item.
	typedef struct packed {
		logic [7:0] pixel;
		logic       pixel_valid;
		logic       line_begin;
		logic       vsync_level;
		logic       last;
	} out_res_t;

	// Shared adder operation.
	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage

`default_nettype wire

[hdl/stlsu_alu.sv]
// Shared add/subtract unit of the tile line scanner.
// Depends on stlsu_pkg for the request and response structs.
`default_nettype none

module stlsu_alu (
	input  stlsu_pkg::alu_req_t req,
	output stlsu_pkg::alu_rsp_t rsp
);

	logic [stlsu_pkg::ALU_W:0] ext;

	// One extra bit gives the carry on add and the borrow on subtract.
	always_comb begin
		case (req.op)
			stlsu_pkg::ALU_ADD: ext = {1'b0, req.a} + {1'b0, req.b};
			stlsu_pkg::ALU_SUB: ext = {1'b0, req.a} - {1'b0, req.b};
			default:            ext = '0;
		endcase
	end

	assign rsp.sum   = ext[stlsu_pkg::ALU_W-1:0];
	assign rsp.carry = ext[stlsu_pkg::ALU_W];

endmodule

`default_nettype wire

[hdl/stlsu_store.sv]
// Tile store: single write port, single read port with registered read data.
// No package dependency.
`default_nettype none

module stlsu_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem [DEPTH];

	// Write and read in the same clocked block; read data is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/scrolling_tile_line_scanner_unit.sv]
// Scrolling tile line scanner. A store write is taken from idle and leaves busy low.
// A visible tick runs scroll_x/ROW_ELEMENTS+1 normalize steps, a base step, ROW_ELEMENTS
// reads and a counter step on the shared adder. Each read's pixel is strobed from the
// registered read data, one result a cycle, never stalled. A blank tick strobes its one
// result in the next cycle. After reset a clearing pass writes 192 to all STORE_DEPTH
// entries, one per cycle, busy high.
`default_nettype none

module scrolling_tile_line_scanner_unit #(
	parameter int STORE_DEPTH  = 1024,
	parameter int ROW_ELEMENTS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire stlsu_pkg::in_req_t               req,
	output logic                                  done,
	output stlsu_pkg::out_res_t                   result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [stlsu_pkg::CFG_IW-1:0]     cfg_index,
	input  wire logic [stlsu_pkg::CFG_DW-1:0]     cfg_data
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int KW  = $clog2(ROW_ELEMENTS);
	localparam int XW  = (KW > 5) ? KW : 5;
	localparam int AL  = stlsu_pkg::ALU_W;
	localparam int LW  = stlsu_pkg::LINE_W;

	localparam logic [AL-1:0] RowElem  = AL'(ROW_ELEMENTS);
	localparam logic [XW-1:0] ColLast  = XW'(ROW_ELEMENTS - 1);
	localparam logic [KW-1:0] KLast    = KW'(ROW_ELEMENTS - 1);
	localparam logic [AW-1:0] ClrLast  = AW'(STORE_DEPTH - 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_NORM   = 6'b000100,
		ST_BASE   = 6'b001000,
		ST_READ   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LW-1:0] first_line_q;
	logic [LW-1:0] end_line_q;
	logic [LW-1:0] vsync_on_q;
	logic [LW-1:0] vsync_off_q;
	logic [3:0]    row_shift_q;
	logic [4:0]    scroll_x_q;
	logic [9:0]    scroll_y_q;

	// Sequencer and line state.
	logic [LW-1:0] line_count_q;
	logic          vsync_q;
	logic [AW-1:0] clr_q;
	logic          done_s1;

	// Working registers of one tick.
	logic [XW-1:0] col_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] base_q;
	logic [AL-1:0] rowprod_q;
	logic          pvalid_s1;
	logic          begin_s1;
	logic          last_s1;

	logic          accept;
	logic          tick;
	logic [9:0]    row;
	logic [LW-1:0] line_next;

	stlsu_pkg::alu_req_t alu_req;
	stlsu_pkg::alu_rsp_t alu_rsp;

	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [7:0]    st_wdata;
	logic          st_re;
	logic [7:0]    st_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign tick      = accept & ~req.req_type;

	// Tile row of a visible line; shifts of ten or more give row zero.
	assign row       = line_count_q[9:0] >> row_shift_q;
	assign line_next = alu_rsp.sum[LW-1:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= stlsu_pkg::FIRST_LINE_RST;
			end_line_q   <= stlsu_pkg::END_LINE_RST;
			vsync_on_q   <= stlsu_pkg::VSYNC_ON_RST;
			vsync_off_q  <= stlsu_pkg::VSYNC_OFF_RST;
			row_shift_q  <= stlsu_pkg::ROW_SHIFT_RST;
			scroll_x_q   <= stlsu_pkg::SCROLL_X_RST;
			scroll_y_q   <= stlsu_pkg::SCROLL_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stlsu_pkg::REG_FIRST_LINE: first_line_q <= cfg_data[LW-1:0];
				stlsu_pkg::REG_END_LINE:   end_line_q   <= cfg_data[LW-1:0];
				stlsu_pkg::REG_VSYNC_ON:   vsync_on_q   <= cfg_data[LW-1:0];
				stlsu_pkg::REG_VSYNC_OFF:  vsync_off_q  <= cfg_data[LW-1:0];
				stlsu_pkg::REG_ROW_SHIFT:  row_shift_q  <= cfg_data[3:0];
				stlsu_pkg::REG_SCROLL_X:   scroll_x_q   <= cfg_data[4:0];
				stlsu_pkg::REG_SCROLL_Y:   scroll_y_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared adder, one job for each of NORM, BASE, READ and FINISH.
	always_comb begin
		alu_req.op = stlsu_pkg::ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
			ST_NORM: begin
				alu_req.op = stlsu_pkg::ALU_SUB;
				alu_req.a  = AL'(col_q);
				alu_req.b  = RowElem;
			end
			ST_BASE: begin
				alu_req.a  = rowprod_q;
				alu_req.b  = AL'(scroll_y_q);
			end
			ST_READ: begin
				alu_req.a  = AL'(base_q);
				alu_req.b  = AL'(col_q);
			end
			ST_FINISH: begin
				alu_req.a  = AL'(line_count_q);
				alu_req.b  = AL'(1'b1);
			end
			default: ;
		endcase
	end

	stlsu_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Store ports: clearing pass, request writes, and row reads.
	always_comb begin
		st_we    = (state_q == ST_CLEAR) | (accept & req.req_type);
		st_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(req.wr_addr);
		st_wdata = (state_q == ST_CLEAR) ? stlsu_pkg::TRANSPARENT : req.wr_byte;
		st_re    = (state_q == ST_READ);
	end

	stlsu_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (st_wdata),
		.re      (st_re),
		.raddr   (alu_rsp.sum[AW-1:0]),
		.rdata_q (st_rdata)
	);

	// Sequencer, line counter and vsync level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			line_count_q <= stlsu_pkg::FIRST_LINE_RST;
			vsync_q      <= 1'b0;
			done_s1      <= 1'b0;
		end else begin
			done_s1 <= (tick & line_count_q[LW-1]) | (state_q == ST_READ);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ClrLast) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (tick) begin
						// On and off on the same line leaves the level on.
						if (line_count_q == vsync_on_q) begin
							vsync_q <= 1'b1;
						end else if (line_count_q == vsync_off_q) begin
							vsync_q <= 1'b0;
						end
						state_q <= line_count_q[LW-1] ? ST_FINISH : ST_NORM;
					end
				end
				ST_NORM: begin
					if (alu_rsp.carry) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (k_q == KLast) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					line_count_q <= (line_next == end_line_q) ? first_line_q : line_next;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers; a blank tick preloads the single blank result's flags.
	always_ff @(posedge clk) begin
		if (tick) begin
			col_q     <= XW'(scroll_x_q);
			k_q       <= '0;
			rowprod_q <= AL'(row) * RowElem;
			pvalid_s1 <= 1'b0;
			begin_s1  <= 1'b1;
			last_s1   <= 1'b1;
		end
		if (state_q == ST_NORM && !alu_rsp.carry) begin
			col_q <= alu_rsp.sum[XW-1:0];
		end
		if (state_q == ST_BASE) begin
			base_q <= alu_rsp.sum[AW-1:0];
		end
		if (state_q == ST_READ) begin
			col_q     <= (col_q == ColLast) ? '0 : col_q + 1'b1;
			k_q       <= k_q + 1'b1;
			pvalid_s1 <= 1'b1;
			begin_s1  <= (k_q == '0);
			last_s1   <= (k_q == KLast);
		end
	end

	// Result ports.
	assign done               = done_s1;
	assign result.pixel       = pvalid_s1 ? st_rdata : 8'd0;
	assign result.pixel_valid = pvalid_s1;
	assign result.line_begin  = begin_s1;
	assign result.vsync_level = vsync_q;
	assign result.last        = last_s1;

endmodule

`default_nettype wire

[hdl/stlsu_checker.sv]
// Port-level checker for the tile line scanner, bound to the top level.
// Depends on stlsu_pkg and the assertion macro header.
`default_nettype none
`include "scrolling_tile_line_scanner_unit_assert.svh"

module stlsu_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire stlsu_pkg::in_req_t  req,
	input wire logic                done,
	input wire stlsu_pkg::out_res_t result
);

	// Results only come out while a tick is still being worked on.
	`STLSU_ASSERT_NOW(a_done_while_busy, done, busy, "result outside a busy tick")

	// A blank line is a single result that both opens and closes the line.
	`STLSU_ASSERT_NOW(a_blank_single, done && !result.pixel_valid, result.line_begin && result.last, "blank result not alone")

	// The first pixel of a visible line is followed directly by another result.
	`STLSU_ASSERT_NEXT(a_visible_stream, done && result.pixel_valid && result.line_begin, done, "gap in visible line")

	// The last result of a tick is not followed directly by another.
	`STLSU_ASSERT_NEXT(a_last_ends, done && result.last, !done, "result after last of tick")

	// An accepted line tick keeps the block busy in the next cycle.
	`STLSU_ASSERT_NEXT(a_tick_busy, start && !busy && !req.req_type, busy, "tick did not hold busy")

endmodule

bind scrolling_tile_line_scanner_unit stlsu_checker u_stlsu_checker (.*);

`default_nettype wire
